[rtl/lrcg_pkg.sv]
package lrcg_pkg;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_CODE    = 3'd1,
    REQ_CLICK   = 3'd2,
    REQ_HOLD    = 3'd3,
    REQ_RELEASE = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    OUT_NONE      = 4'd0,
    OUT_ADDED     = 4'd1,
    OUT_DUPLICATE = 4'd2,
    OUT_FULL      = 4'd3,
    OUT_REMOVED   = 4'd4,
    OUT_ABSENT    = 4'd5,
    OUT_MATCHED   = 4'd6,
    OUT_UNKNOWN   = 4'd7,
    OUT_DROPPED   = 4'd8
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_ENABLE        = 2'd0,
    CFG_LOCKOUT_MS    = 2'd1,
    CFG_LEARN_TIMEOUT = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgWidth = 16;
  localparam logic [15:0] LockoutReset = 16'd800;
  localparam logic [15:0] LearnTimeoutReset = 16'd10000;

  typedef struct packed {
    logic clear;
    logic scan;
    logic compact;
    logic append;
  } cell_ctrl_t;

endpackage

[rtl/lrcg_cell.sv]
module lrcg_cell import lrcg_pkg::*; #(
  parameter int unsigned CODE_BITS = 32,
  parameter int unsigned CNT_BITS  = 8,
  parameter int unsigned INDEX     = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [CODE_BITS-1:0] key_i,
  input  logic [CNT_BITS-1:0]  count_i,
  input  logic                 mark_i,
  input  logic [CODE_BITS-1:0] code_up_i,
  output logic                 mark_o,
  output logic [CODE_BITS-1:0] code_o
);

  logic [CODE_BITS-1:0] code_q;
  logic                 mark_q;
  logic                 hit;

  assign hit = (code_q == key_i) && (CNT_BITS'(INDEX) < count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      mark_q <= 1'b0;
    end else if (ctrl_i.scan) begin
      mark_q <= mark_i | hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.compact && mark_q) begin
      code_q <= code_up_i;
    end else if (ctrl_i.append && (count_i == CNT_BITS'(INDEX))) begin
      code_q <= key_i;
    end
  end

  assign mark_o = mark_q;
  assign code_o = code_q;

endmodule

[rtl/lrcg_chain.sv]
module lrcg_chain import lrcg_pkg::*; #(
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned CODE_BITS = 32,
  parameter int unsigned CNT_BITS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [CODE_BITS-1:0] key_i,
  input  logic [CNT_BITS-1:0]  count_i,
  output logic                 found_o
);

  logic [DEPTH-1:0]     mark;
  logic [DEPTH-1:0]     mark_in;
  logic [CODE_BITS-1:0] code [DEPTH];
  logic [CODE_BITS-1:0] code_up [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign mark_in[i] = 1'b0;
    end else begin : g_rest
      assign mark_in[i] = mark[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign code_up[i] = code[i];
    end else begin : g_inner
      assign code_up[i] = code[i+1];
    end

    lrcg_cell #(
      .CODE_BITS (CODE_BITS),
      .CNT_BITS  (CNT_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .key_i     (key_i),
      .count_i   (count_i),
      .mark_i    (mark_in[i]),
      .code_up_i (code_up[i]),
      .mark_o    (mark[i]),
      .code_o    (code[i])
    );
  end

  assign found_o = mark[DEPTH-1];

endmodule

[rtl/learned_remote_code_gate.sv]
// Learned remote code table with gate toggle decision. Ticks, clicks and long-press
// events need no scan: the result strobe done_o rises in the cycle after start,
// and busy stays low, so one such word can follow every cycle. A received code that is
// not dropped and not refused as full walks a match token down a row of TABLE_DEPTH
// cells, one cell per cycle, in ST_SCAN; the result word is registered in ST_FINISH
// after it, and busy is high meanwhile. Deletion compacts the row in the final cycle.
// Results cannot be stalled: done_o is high for a single cycle per result word, and
// outcome_o holds until the next word is taken. No clearing pass follows reset.
module learned_remote_code_gate import lrcg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned CODE_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type_i,
  input  logic [31:0]         code_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic                toggle_pulse_o,
  output logic [3:0]          outcome_o,
  output logic                learning_active_o,
  output logic                deleting_active_o,
  output logic                led_lit_o,
  output logic [7:0]          entry_total_o
);

  localparam int unsigned CntBits  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ScanBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL,
    OP_MATCH
  } op_e;

  state_e                state_q;
  op_e                   op_q;
  logic [ScanBits-1:0]   scan_cnt_q;
  logic [CODE_BITS-1:0]  key_q;
  logic [CntBits-1:0]    count_q;
  logic                  learning_q;
  logic                  deleting_q;
  logic                  lamp_q;
  logic                  lockout_q;
  logic [15:0]           lock_el_q;
  logic [15:0]           learn_el_q;
  logic                  enable_q;
  logic [15:0]           lockout_ms_q;
  logic [15:0]           learn_to_q;
  logic                  done_q;
  logic                  pulse_q;
  outcome_e              outcome_q;

  logic                  accept;
  logic                  found;
  cell_ctrl_t            ctrl;
  logic [CODE_BITS+31:0] key_ext;
  logic [CntBits+7:0]    total_ext;

  assign accept    = start && !busy;
  assign key_ext   = {{CODE_BITS{1'b0}}, code_i};
  assign total_ext = {8'b0, count_q};

  always_comb begin
    ctrl.clear   = accept;
    ctrl.scan    = (state_q == ST_SCAN);
    ctrl.compact = (state_q == ST_FINISH) && (op_q == OP_DEL) && found;
    ctrl.append  = (state_q == ST_FINISH) && (op_q == OP_ADD) && !found;
  end

  lrcg_chain #(
    .DEPTH     (TABLE_DEPTH),
    .CODE_BITS (CODE_BITS),
    .CNT_BITS  (CntBits)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .key_i   (key_q),
    .count_i (count_q),
    .found_o (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      lockout_ms_q <= LockoutReset;
      learn_to_q   <= LearnTimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLE:        enable_q     <= cfg_wdata_i[0];
        CFG_LOCKOUT_MS:    lockout_ms_q <= cfg_wdata_i;
        CFG_LEARN_TIMEOUT: learn_to_q   <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_ext[CODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_MATCH;
      scan_cnt_q <= '0;
      count_q    <= '0;
      learning_q <= 1'b0;
      deleting_q <= 1'b0;
      lamp_q     <= 1'b0;
      lockout_q  <= 1'b0;
      lock_el_q  <= '0;
      learn_el_q <= '0;
      done_q     <= 1'b0;
      pulse_q    <= 1'b0;
      outcome_q  <= OUT_NONE;
    end else begin
      done_q  <= 1'b0;
      pulse_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            scan_cnt_q <= '0;
            outcome_q  <= OUT_NONE;
            done_q     <= 1'b1;
            unique case (req_type_i)
              REQ_TICK: begin
                if (learning_q) begin
                  if (learn_el_q >= learn_to_q) begin
                    learning_q <= 1'b0;
                    lamp_q     <= 1'b0;
                    learn_el_q <= '0;
                  end else begin
                    learn_el_q <= learn_el_q + 16'd1;
                  end
                end
                if (lockout_q) begin
                  if (lock_el_q >= lockout_ms_q) begin
                    lockout_q <= 1'b0;
                  end else begin
                    lock_el_q <= lock_el_q + 16'd1;
                  end
                end
              end
              REQ_CODE: begin
                if (lockout_q || !enable_q) begin
                  outcome_q <= OUT_DROPPED;
                end else begin
                  lockout_q <= 1'b1;
                  lock_el_q <= '0;
                  if (learning_q) begin
                    learning_q <= 1'b0;
                    lamp_q     <= 1'b0;
                    learn_el_q <= '0;
                    if (count_q == CntBits'(TABLE_DEPTH)) begin
                      outcome_q <= OUT_FULL;
                    end else begin
                      op_q    <= OP_ADD;
                      state_q <= ST_SCAN;
                      done_q  <= 1'b0;
                    end
                  end else if (deleting_q) begin
                    op_q    <= OP_DEL;
                    state_q <= ST_SCAN;
                    done_q  <= 1'b0;
                  end else begin
                    op_q    <= OP_MATCH;
                    state_q <= ST_SCAN;
                    done_q  <= 1'b0;
                  end
                end
              end
              REQ_CLICK: begin
                learning_q <= !learning_q;
                lamp_q     <= !learning_q;
                learn_el_q <= '0;
              end
              REQ_HOLD: begin
                if (!deleting_q) begin
                  lamp_q     <= 1'b1;
                  deleting_q <= 1'b1;
                end
              end
              REQ_RELEASE: begin
                lamp_q     <= 1'b0;
                deleting_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_cnt_q == ScanBits'(TABLE_DEPTH - 1)) begin
            state_q <= ST_FINISH;
          end else begin
            scan_cnt_q <= scan_cnt_q + ScanBits'(1);
          end
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          unique case (op_q)
            OP_ADD: begin
              if (found) begin
                outcome_q <= OUT_DUPLICATE;
              end else begin
                outcome_q <= OUT_ADDED;
                count_q   <= count_q + CntBits'(1);
              end
            end
            OP_DEL: begin
              if (found) begin
                outcome_q <= OUT_REMOVED;
                count_q   <= count_q - CntBits'(1);
              end else begin
                outcome_q <= OUT_ABSENT;
              end
            end
            default: begin
              if (found) begin
                outcome_q <= OUT_MATCHED;
                pulse_q   <= 1'b1;
              end else begin
                outcome_q <= OUT_UNKNOWN;
              end
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign toggle_pulse_o    = pulse_q;
  assign outcome_o         = outcome_q;
  assign learning_active_o = learning_q;
  assign deleting_active_o = deleting_q;
  assign led_lit_o         = lamp_q;
  assign entry_total_o     = total_ext[7:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_pulse_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    toggle_pulse_o |-> (done_o && (outcome_o == OUT_MATCHED)))
    else $error("toggle pulse without matched result");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without a result word");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import lrcg_pkg::*;

  localparam int TableDepth = 128;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] code;
  } gate_word_t;

  typedef struct packed {
    logic       toggle;
    outcome_e   outcome;
    logic       learning;
    logic       deleting;
    logic       led;
    logic [7:0] total;
  } gate_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic [2:0]          req_type_i = '0;
  logic [31:0]         code_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_addr_i = '0;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;
  logic                busy;
  logic                done_o;
  logic                toggle_pulse_o;
  logic [3:0]          outcome_o;
  logic                learning_active_o;
  logic                deleting_active_o;
  logic                led_lit_o;
  logic [7:0]          entry_total_o;

  learned_remote_code_gate #(
    .TABLE_DEPTH(TableDepth),
    .CODE_BITS  (32)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .code_i           (code_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .toggle_pulse_o   (toggle_pulse_o),
    .outcome_o        (outcome_o),
    .learning_active_o(learning_active_o),
    .deleting_active_o(deleting_active_o),
    .led_lit_o        (led_lit_o),
    .entry_total_o    (entry_total_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  gate_word_t   feed[$];
  gate_result_t due_results[$];
  logic [31:0]  code_pool[$];
  int           words_made = 0;
  int           idle_pct = 12;
  int           error_count = 0;
  int           cycle_count = 0;
  bit           word_taken = 1'b0;

  // shadow of the gate state and its registers
  logic [31:0] held_codes[TableDepth];
  int          held_count = 0;
  logic        learning_on = 1'b0;
  logic        deleting_on = 1'b0;
  logic        lamp_on = 1'b0;
  logic        lockout_on = 1'b0;
  logic [15:0] lockout_ticks = '0;
  logic [15:0] learn_ticks = '0;
  logic        cfg_enable = 1'b1;
  logic [15:0] cfg_lockout = LockoutReset;
  logic [15:0] cfg_learn_timeout = LearnTimeoutReset;

  function automatic int find_held(input logic [31:0] c);
    for (int i = 0; i < held_count; i++) begin
      if (held_codes[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void end_learning();
    learning_on = 1'b0;
    lamp_on = 1'b0;
    learn_ticks = '0;
  endfunction

  function automatic gate_result_t gate_predict(input gate_word_t w);
    gate_result_t r;
    int hit;
    r.toggle = 1'b0;
    r.outcome = OUT_NONE;
    case (w.kind)
      REQ_TICK: begin
        if (learning_on) begin
          if (learn_ticks >= cfg_learn_timeout) end_learning();
          else learn_ticks = learn_ticks + 16'd1;
        end
        if (lockout_on) begin
          if (lockout_ticks >= cfg_lockout) lockout_on = 1'b0;
          else lockout_ticks = lockout_ticks + 16'd1;
        end
      end
      REQ_CODE: begin
        if (lockout_on || !cfg_enable) begin
          r.outcome = OUT_DROPPED;
        end else begin
          hit = find_held(w.code);
          if (learning_on) begin
            if (held_count >= TableDepth) begin
              r.outcome = OUT_FULL;
            end else if (hit >= 0) begin
              r.outcome = OUT_DUPLICATE;
            end else begin
              held_codes[held_count] = w.code;
              held_count++;
              r.outcome = OUT_ADDED;
            end
            end_learning();
          end else if (deleting_on) begin
            if (hit < 0) begin
              r.outcome = OUT_ABSENT;
            end else begin
              for (int i = hit; i + 1 < held_count; i++) held_codes[i] = held_codes[i + 1];
              held_count--;
              r.outcome = OUT_REMOVED;
            end
          end else if (hit >= 0) begin
            r.outcome = OUT_MATCHED;
            r.toggle = 1'b1;
          end else begin
            r.outcome = OUT_UNKNOWN;
          end
          lockout_on = 1'b1;
          lockout_ticks = '0;
        end
      end
      REQ_CLICK: begin
        learning_on = !learning_on;
        lamp_on = learning_on;
        learn_ticks = '0;
      end
      REQ_HOLD: begin
        if (!deleting_on) begin
          lamp_on = 1'b1;
          deleting_on = 1'b1;
        end
      end
      REQ_RELEASE: begin
        lamp_on = 1'b0;
        deleting_on = 1'b0;
      end
      default: begin
      end
    endcase
    r.learning = learning_on;
    r.deleting = deleting_on;
    r.led = lamp_on;
    r.total = 8'(held_count);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (word_taken) begin
      void'(feed.pop_front());
      word_taken = 1'b0;
    end
    if (rst_ni && feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      req_type_i <= feed[0].kind;
      code_i <= feed[0].code;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    gate_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with none outstanding, actual outcome %0h", $time,
                   outcome_o);
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("toggle_pulse", want.toggle, toggle_pulse_o);
          check_field("outcome", want.outcome, outcome_o);
          check_field("learning_active", want.learning, learning_active_o);
          check_field("deleting_active", want.deleting, deleting_active_o);
          check_field("led_lit", want.led, led_lit_o);
          check_field("entry_total", want.total, entry_total_o);
        end
      end
      if (start && !busy) begin
        due_results.push_back(gate_predict('{kind: req_type_i, code: code_i}));
        word_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_word(input logic [2:0] kind, input logic [31:0] c);
    feed.push_back('{kind: kind, code: c});
    words_made++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_word(REQ_TICK, $urandom);
  endtask

  function automatic logic [31:0] fresh_code();
    logic [31:0] c;
    c = $urandom;
    code_pool.push_back(c);
    return c;
  endfunction

  function automatic logic [31:0] pool_code();
    if (code_pool.size() == 0) return $urandom;
    return code_pool[$urandom_range(code_pool.size() - 1)];
  endfunction

  function automatic int lock_gap();
    int full_gap;
    full_gap = (cfg_lockout < 16'd8) ? int'(cfg_lockout) + 1 : int'($urandom_range(3));
    return ($urandom_range(99) < 85) ? full_gap : int'($urandom_range(full_gap));
  endfunction

  function automatic int learn_gap();
    int lim;
    lim = (cfg_learn_timeout < 16'd8) ? int'(cfg_learn_timeout) + 1 : 3;
    return int'($urandom_range(lim));
  endfunction

  task automatic make_words(input int count, input bit fill);
    int base;
    int roll;
    base = words_made;
    while (words_made - base < count) begin
      roll = $urandom_range(99);
      if (fill ? roll < 95 : roll < 30) begin
        push_ticks(lock_gap());
        push_word(REQ_CLICK, $urandom);
        if (!fill) push_ticks(learn_gap());
        push_word(REQ_CODE, (fill || $urandom_range(1)) ? fresh_code() : pool_code());
      end else if (roll < (fill ? 97 : 50)) begin
        push_ticks(lock_gap());
        push_word(REQ_HOLD, $urandom);
        push_word(REQ_CODE, pool_code());
        if ($urandom_range(3) != 0) push_word(REQ_RELEASE, $urandom);
      end else if (roll < (fill ? 98 : 80)) begin
        push_ticks(lock_gap());
        push_word(REQ_CODE, pool_code());
      end else begin
        repeat ($urandom_range(4, 1)) push_word(3'($urandom_range(7)), $urandom);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (feed.size() != 0 || due_results.size() != 0 || start) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic en, input logic [15:0] lock, input logic [15:0] learn);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_ENABLE;
    cfg_wdata_i <= CfgWidth'(en);
    @(negedge clk_i);
    cfg_addr_i <= CFG_LOCKOUT_MS;
    cfg_wdata_i <= lock;
    @(negedge clk_i);
    cfg_addr_i <= CFG_LEARN_TIMEOUT;
    cfg_wdata_i <= learn;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_enable = en;
    cfg_lockout = lock;
    cfg_learn_timeout = learn;
  endtask

  task automatic run_phase(input int idle, input logic en, input logic [15:0] lock,
                           input logic [15:0] learn, input int count, input bit fill);
    settle();
    write_regs(en, lock, learn);
    idle_pct = idle;
    make_words(count, fill);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: long lockout, long learning window
    push_word(REQ_TICK, 32'h0);
    push_word(REQ_CODE, 32'h0000_0000);
    push_word(REQ_CODE, 32'hFFFF_FFFF);
    push_word(3'd7, 32'hFFFF_FFFF);
    push_word(REQ_CLICK, 32'h0);
    push_word(REQ_CLICK, 32'h0);
    push_word(REQ_HOLD, 32'h0);
    push_word(REQ_HOLD, 32'h0);
    push_word(REQ_RELEASE, 32'h0);
    settle();

    // learn, duplicate, match, learn over delete, remove, absent
    write_regs(1'b1, 16'd1, 16'd1);
    push_ticks(2);
    push_word(REQ_CLICK, 32'h0);
    push_word(REQ_CODE, 32'h0000_0000);
    push_ticks(2);
    push_word(REQ_CLICK, 32'h0);
    push_word(REQ_CODE, 32'h0000_0000);
    push_ticks(2);
    push_word(REQ_CODE, 32'h0000_0000);
    push_ticks(2);
    push_word(REQ_HOLD, 32'h0);
    push_word(REQ_CLICK, 32'h0);
    push_word(REQ_CODE, 32'hFFFF_FFFF);
    push_ticks(2);
    push_word(REQ_CODE, 32'h0000_0000);
    push_ticks(2);
    push_word(REQ_CODE, 32'h0000_0005);
    push_word(REQ_RELEASE, 32'h0);

    run_phase(12, 1'b1, 16'd1, 16'd3, 240, 1'b0);
    run_phase(12, 1'b1, 16'd1, 16'd1, 360, 1'b1);
    run_phase(69, 1'b0, 16'd1, 16'd65535, 60, 1'b0);
    run_phase(69, 1'b1, 16'd65535, 16'd65535, 60, 1'b0);
    run_phase(69, 1'b1, 16'd3, 16'd10, 200, 1'b0);
    run_phase(0, 1'b1, 16'd1, 16'd2, 280, 1'b1);
    settle();
    repeat (TableDepth + 8) @(negedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lrcg_pkg.sv
rtl/lrcg_cell.sv
rtl/lrcg_chain.sv
rtl/learned_remote_code_gate.sv
sim/tb.sv
